// File: design/sorted_letter_freq_chi_square_defines.svh
// Assertion macros shared by the letter-frequency score block
`ifndef SORTED_LETTER_FREQ_CHI_SQUARE_DEFINES_SVH
`define SORTED_LETTER_FREQ_CHI_SQUARE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst
`define SLFCS_ASSERT_SAME(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (con)) else $error(msg);

// Next-cycle implication, sampled on clk, off during rst
`define SLFCS_ASSERT_NEXT(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (con)) else $error(msg);

`endif

// File: design/slfcs_pkg.sv
// Types, constants and reference table for the letter-frequency score block
package slfcs_pkg;

  localparam int LETTERS   = 26;
  localparam int IDX_W     = 5;
  localparam int REF_W     = 20;
  localparam int FREQ_W    = 23;
  localparam int SQ_W      = 46;
  localparam int TERM_W    = 35;
  localparam int SUM_W     = 40;
  localparam int SCALED_W  = 47;
  localparam int SCORE_W   = 31;
  localparam int FRAC_BITS = 16;

  localparam logic [7:0] LETTER_A = 8'h41;
  localparam logic [7:0] LETTER_Z = 8'h5A;

  // Descending English letter percentages, Q16
  localparam logic [REF_W-1:0] REF_Q16 [LETTERS] = '{
    20'd851968, 20'd596378, 20'd537395, 20'd491520, 20'd458752, 20'd439091,
    20'd412877, 20'd399770, 20'd393216, 20'd281805, 20'd262144, 20'd183501,
    20'd183501, 20'd157286, 20'd157286, 20'd144179, 20'd131072, 20'd131072,
    20'd124518, 20'd98304,  20'd64225,  20'd50463,  20'd9830,   20'd9830,
    20'd6226,   20'd4850
  };

  typedef enum logic [10:0] {
    ST_COUNT  = 11'b000_0000_0001,
    ST_SORT   = 11'b000_0000_0010,
    ST_FSTART = 11'b000_0000_0100,
    ST_FWAIT  = 11'b000_0000_1000,
    ST_SQUARE = 11'b000_0001_0000,
    ST_TSTART = 11'b000_0010_0000,
    ST_TWAIT  = 11'b000_0100_0000,
    ST_SCALE1 = 11'b000_1000_0000,
    ST_SCALE2 = 11'b001_0000_0000,
    ST_FINISH = 11'b010_0000_0000,
    ST_SPARE  = 11'b100_0000_0000
  } state_t;

  typedef struct packed {
    logic             count;
    logic             clear;
    logic             sort;
    logic             phase;
    logic             fstart;
    logic             tstart;
    logic             cap_diff;
    logic             square;
    logic             acc;
    logic             scale1;
    logic             scale2;
    logic             load;
    logic [IDX_W-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic out_busy;
  } stat_t;

endpackage

// File: design/slfcs_div.sv
// Restoring divider, one quotient bit per cycle
module slfcs_div #(
  parameter int DVD_W = 46,
  parameter int DVS_W = 20
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             busy,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVS_W-1:0] dvs;
  logic [DVS_W-1:0] rem;
  logic [DVD_W-1:0] quo;
  logic [CNT_W-1:0] steps;
  logic [DVS_W:0]   trial;
  logic             fits;

  // Shift the next dividend bit into the partial remainder and try a subtract
  assign trial    = {rem, quo[DVD_W-1]};
  assign fits     = trial >= {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      steps <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      steps <= CNT_W'(DVD_W);
    end else if (busy) begin
      steps <= steps - 1'b1;
      if (steps == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvs <= divisor;
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      rem <= fits ? DVS_W'(trial - {1'b0, dvs}) : trial[DVS_W-1:0];
      quo <= {quo[DVD_W-2:0], fits};
    end
  end

endmodule

// File: design/slfcs_dp.sv
// Datapath: letter histogram, sorting cells, divider, accumulator, output word
module slfcs_dp #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  slfcs_pkg::cmd_t                  cmd,
  input  logic [7:0]                       char_byte,
  input  logic                             out_ready,
  output slfcs_pkg::stat_t                 stat,
  output logic                             out_valid,
  output logic [slfcs_pkg::SCORE_W-1:0]    score,
  output logic                             empty_text,
  output logic                             count_overflow
);
  import slfcs_pkg::*;

  localparam int CW    = COUNT_WIDTH;
  localparam int FNUM_W = CW + FREQ_W;
  localparam int DVD_W = (FNUM_W > SQ_W) ? FNUM_W : SQ_W;
  localparam int DVS_W = (CW > REF_W) ? CW : REF_W;
  localparam logic [CW-1:0] CNT_MAX = '1;

  logic [CW-1:0]       cnt      [LETTERS];
  logic [CW-1:0]       cnt_next [LETTERS];
  logic [CW-1:0]       len, len_next;
  logic                ovf, ovf_next;
  logic                is_letter;
  logic [IDX_W-1:0]    lidx;
  logic [FNUM_W-1:0]   fnum;
  logic [REF_W-1:0]    ref_val;
  logic [FREQ_W-1:0]   freq;
  logic [FREQ_W-1:0]   diff;
  logic [SQ_W-1:0]     sq;
  logic [SUM_W-1:0]    sum;
  logic [SCALED_W-1:0] scaled;
  logic                div_start;
  logic                div_busy;
  logic [DVD_W-1:0]    div_dvd;
  logic [DVS_W-1:0]    div_dvs;
  logic [DVD_W-1:0]    div_quo;

  assign is_letter = (char_byte >= LETTER_A) && (char_byte <= LETTER_Z);
  assign lidx      = IDX_W'(char_byte - LETTER_A);

  // Histogram and length: bump, sort, shift out, clear
  always_comb begin
    cnt_next = cnt;
    len_next = len;
    ovf_next = ovf;
    priority if (cmd.clear) begin
      for (int k = 0; k < LETTERS; k++) cnt_next[k] = '0;
      len_next = '0;
      ovf_next = 1'b0;
    end else if (cmd.count) begin
      if (len == CNT_MAX) ovf_next = 1'b1;
      else len_next = len + 1'b1;
      for (int k = 0; k < LETTERS; k++) begin
        if (is_letter && (lidx == IDX_W'(k))) begin
          if (cnt[k] == CNT_MAX) ovf_next = 1'b1;
          else cnt_next[k] = cnt[k] + 1'b1;
        end
      end
    end else if (cmd.sort) begin
      // odd-even transposition pass, larger count moves to the front
      for (int k = 0; k < LETTERS - 1; k++) begin
        if (((k % 2) == int'(cmd.phase)) && (cnt[k] < cnt[k+1])) begin
          cnt_next[k]   = cnt[k+1];
          cnt_next[k+1] = cnt[k];
        end
      end
    end else if (cmd.acc) begin
      for (int k = 0; k < LETTERS - 1; k++) cnt_next[k] = cnt[k+1];
      cnt_next[LETTERS-1] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < LETTERS; k++) cnt[k] <= '0;
      len <= '0;
      ovf <= 1'b0;
    end else begin
      cnt <= cnt_next;
      len <= len_next;
      ovf <= ovf_next;
    end
  end

  // Feed the shared divider: count*100 in Q16 over length, or square over reference
  assign fnum      = {(CW + 7)'(cnt[0]) * (CW + 7)'(100), {FRAC_BITS{1'b0}}};
  assign ref_val   = REF_Q16[cmd.idx];
  assign div_start = cmd.fstart | cmd.tstart;
  assign div_dvd   = cmd.fstart ? DVD_W'(fnum) : DVD_W'(sq);
  assign div_dvs   = cmd.fstart ? DVS_W'(len) : DVS_W'(ref_val);
  assign freq      = div_quo[FREQ_W-1:0];

  slfcs_div #(
    .DVD_W(DVD_W),
    .DVS_W(DVS_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .busy     (div_busy),
    .quotient (div_quo)
  );

  // Difference, square, sum and the scaling by 1000 / 2^16
  always_ff @(posedge clk) begin
    if (cmd.cap_diff) begin
      diff <= (freq >= FREQ_W'(ref_val)) ? freq - FREQ_W'(ref_val)
                                         : FREQ_W'(ref_val) - freq;
    end
    if (cmd.square) begin
      sq <= SQ_W'(diff) * SQ_W'(diff);
    end
    if (cmd.scale1) begin
      scaled <= (SCALED_W'(sum) << 7) - SCALED_W'(sum);
    end else if (cmd.scale2) begin
      scaled <= scaled - (SCALED_W'(sum) << 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      sum <= '0;
    end else if (cmd.acc) begin
      sum <= sum + SUM_W'(div_quo[TERM_W-1:0]);
    end
  end

  // Output word: load when free, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      empty_text     <= (len == '0);
      count_overflow <= ovf;
      if (len == '0) score <= '0;
      else if (|scaled[SCALED_W-1:SCORE_W+13]) score <= '1;
      else score <= scaled[SCORE_W+12:13];
    end
  end

  assign stat.div_busy = div_busy;
  assign stat.out_busy = out_valid & ~out_ready;

endmodule

// File: design/slfcs_ctrl.sv
// Controller: counting, sort passes, per-letter scoring sequence, result hand-off
module slfcs_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             last,
  input  slfcs_pkg::stat_t stat,
  output logic             in_ready,
  output slfcs_pkg::cmd_t  cmd
);
  import slfcs_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LETTERS - 1);

  state_t           state, state_next;
  logic [IDX_W-1:0] step, step_next;

  always_comb begin
    state_next = state;
    step_next  = step;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.idx    = step;
    unique case (state)
      ST_COUNT: begin
        in_ready  = 1'b1;
        cmd.count = in_valid;
        if (in_valid && last) begin
          state_next = ST_SORT;
          step_next  = '0;
        end
      end
      ST_SORT: begin
        cmd.sort  = 1'b1;
        cmd.phase = step[0];
        if (step == LAST_IDX) begin
          state_next = ST_FSTART;
          step_next  = '0;
        end else begin
          step_next = step + 1'b1;
        end
      end
      ST_FSTART: begin
        cmd.fstart = 1'b1;
        state_next = ST_FWAIT;
      end
      ST_FWAIT: begin
        if (!stat.div_busy) begin
          cmd.cap_diff = 1'b1;
          state_next   = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        cmd.square = 1'b1;
        state_next = ST_TSTART;
      end
      ST_TSTART: begin
        cmd.tstart = 1'b1;
        state_next = ST_TWAIT;
      end
      ST_TWAIT: begin
        if (!stat.div_busy) begin
          cmd.acc = 1'b1;
          if (step == LAST_IDX) begin
            state_next = ST_SCALE1;
          end else begin
            step_next  = step + 1'b1;
            state_next = ST_FSTART;
          end
        end
      end
      ST_SCALE1: begin
        cmd.scale1 = 1'b1;
        state_next = ST_SCALE2;
      end
      ST_SCALE2: begin
        cmd.scale2 = 1'b1;
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (!stat.out_busy) begin
          cmd.load   = 1'b1;
          cmd.clear  = 1'b1;
          state_next = ST_COUNT;
        end
      end
      default: begin
        state_next = ST_COUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_COUNT;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

endmodule

// File: design/sorted_letter_freq_chi_square.sv
// Sorted letter-frequency chi-squared score: top level
//
// Input channel (in_valid/in_ready, char_byte, last) takes one text byte per
// word; every byte adds to the length, 'A'..'Z' also to a 26-entry histogram.
// Counting runs at one word per cycle. The word with last set closes the text.
// Output channel (out_valid/out_ready, score, empty_text, count_overflow)
// carries one word per text: floor(1000 * chi-squared) of the sorted counts
// against an English reference, saturating at 2^31-1.
// After the last byte in_ready drops while the block scores: 26 sort passes,
// then per letter two runs of the shared bit-serial divider, one for the
// frequency and one for the chi-squared term, then the scaling steps and
// the load of the result word. The result sits in an output register, so
// counting of the next text resumes while it waits; if out_ready stays low,
// a second result holds the block until the first is taken.
// Reset (rst, synchronous) empties histogram, length and output register.
module sorted_letter_freq_chi_square #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    char_byte,
  input  logic                          last,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [slfcs_pkg::SCORE_W-1:0] score,
  output logic                          empty_text,
  output logic                          count_overflow
);
  import slfcs_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  slfcs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .last     (last),
    .stat     (stat),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  slfcs_dp #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .char_byte      (char_byte),
    .out_ready      (out_ready),
    .stat           (stat),
    .out_valid      (out_valid),
    .score          (score),
    .empty_text     (empty_text),
    .count_overflow (count_overflow)
  );

`include "sorted_letter_freq_chi_square_defines.svh"

  // Last byte hands over to scoring
  `SLFCS_ASSERT_NEXT(a_last_stalls, in_valid && in_ready && last, !in_ready, "input open after last byte")
  // Never overwrite a result still waiting
  `SLFCS_ASSERT_SAME(a_no_overwrite, cmd.load, !(out_valid && !out_ready), "result overwritten")
  // Divider only runs while input is held off
  `SLFCS_ASSERT_SAME(a_div_idle_in, stat.div_busy, !in_ready, "divider busy while counting")

endmodule

// File: verif/sorted_letter_freq_chi_square_tb.sv
// Testbench for the sorted letter-frequency chi-squared score block
`timescale 1ns / 100ps

module sorted_letter_freq_chi_square_tb;
  import slfcs_pkg::*;

  typedef struct {
    logic [SCORE_W-1:0] score;
    logic               empty_text;
    logic               count_overflow;
  } score_word_t;

  class score_board;
    localparam longint unsigned CNT_MAX = 65535;
    longint unsigned hist[LETTERS];
    longint unsigned text_len;
    bit              sat_seen;
    score_word_t     pending[$];
    int              errors;
    int              texts_scored;
    int              sat_texts;

    function new();
      wipe();
      errors = 0;
      texts_scored = 0;
      sat_texts = 0;
    endfunction

    function void wipe();
      foreach (hist[i]) hist[i] = 0;
      text_len = 0;
      sat_seen = 0;
    endfunction

    // Add one to a counter, saturating at its top value
    function void bump(ref longint unsigned c);
      if (c >= CNT_MAX) sat_seen = 1;
      else c++;
    endfunction

    // Sort the histogram descending and sum the chi-squared terms
    function logic [SCORE_W-1:0] chi_square();
      longint unsigned srt[LETTERS];
      longint unsigned v, freq, rq, d, sum;
      int j;
      sum = 0;
      foreach (srt[i]) srt[i] = hist[i];
      for (int i = 1; i < LETTERS; i++) begin
        v = srt[i];
        j = i - 1;
        while (j >= 0 && srt[j] < v) begin
          srt[j + 1] = srt[j];
          j--;
        end
        srt[j + 1] = v;
      end
      for (int i = 0; i < LETTERS; i++) begin
        freq = ((srt[i] * 100) << FRAC_BITS) / text_len;
        rq = REF_Q16[i];
        d = (freq >= rq) ? freq - rq : rq - freq;
        sum += (d * d) / rq;
      end
      sum = (sum * 1000) >> FRAC_BITS;
      return (sum > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : sum[SCORE_W-1:0];
    endfunction

    // Note an accepted byte; on the last one, queue the expected score word
    function void note_byte(logic [7:0] b, logic l);
      score_word_t w;
      bump(text_len);
      if (b >= LETTER_A && b <= LETTER_Z) bump(hist[b - LETTER_A]);
      if (l) begin
        w.empty_text = (text_len == 0);
        w.score = w.empty_text ? '0 : chi_square();
        w.count_overflow = sat_seen;
        if (sat_seen) sat_texts++;
        pending.push_back(w);
        wipe();
      end
    endfunction

    // Compare one accepted result word with the oldest expectation
    function void check_word(logic [SCORE_W-1:0] s, logic e, logic o);
      score_word_t w;
      texts_scored++;
      if (pending.size() == 0) begin
        $error("unexpected result word: score %0d", s);
        errors++;
        return;
      end
      w = pending.pop_front();
      if (s !== w.score) begin
        $error("score: expected %0d, got %0d", w.score, s);
        errors++;
      end
      if (e !== w.empty_text) begin
        $error("empty_text: expected %0b, got %0b", w.empty_text, e);
        errors++;
      end
      if (o !== w.count_overflow) begin
        $error("count_overflow: expected %0b, got %0b", w.count_overflow, o);
        errors++;
      end
    endfunction
  endclass

  logic               clk = 0;
  logic               rst = 1;
  logic               in_valid = 0;
  logic               in_ready;
  logic [7:0]         char_byte = '0;
  logic               last = 0;
  logic               out_valid;
  logic               out_ready = 0;
  logic [SCORE_W-1:0] score;
  logic               empty_text;
  logic               count_overflow;

  score_board sb = new();
  int  bytes_sent = 0;
  bit  quiet = 0;
  bit  held_once = 0;
  int  hold_left = 0;

  sorted_letter_freq_chi_square DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .char_byte(char_byte), .last(last),
    .out_valid(out_valid), .out_ready(out_ready),
    .score(score), .empty_text(empty_text), .count_overflow(count_overflow)
  );

  always #10 clk = ~clk;

  // Hand one word to the block and wait for it to be taken
  task automatic send_byte(logic [7:0] b, logic l);
    if (!quiet && $urandom_range(99) < 6) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1;
    char_byte <= b;
    last <= l;
    do @(posedge clk); while (!in_ready);
    sb.note_byte(b, l);
    bytes_sent++;
  endtask

  task automatic send_text(logic [7:0] txt[$]);
    foreach (txt[i]) send_byte(txt[i], i == txt.size() - 1);
  endtask

  function automatic logic [7:0] rand_char();
    if ($urandom_range(99) < 75) return 8'(LETTER_A + 8'($urandom_range(25)));
    return 8'($urandom_range(255));
  endfunction

  // Receiver: take words, with random stalls and one long hold-off
  initial begin
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready)
        sb.check_word(score, empty_text, count_overflow);
      if (!held_once && sb.texts_scored == 5) begin
        held_once = 1;
        hold_left = 8000;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 0;
      end else begin
        out_ready <= quiet || ($urandom_range(99) >= 6);
      end
    end
  end

  // Stimulus
  initial begin
    logic [7:0] t[$];
    int n;
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Single-byte texts at the field extremes and letter bounds
    send_byte(8'h41, 1);
    send_byte(8'h5A, 1);
    send_byte(8'h00, 1);
    send_byte(8'hFF, 1);
    send_byte(8'h40, 1);
    send_byte(8'h5B, 1);
    send_byte(8'h61, 1);
    // Every letter once: all counts tie
    t = {};
    for (int i = 0; i < LETTERS; i++) t.push_back(8'(LETTER_A + 8'(i)));
    send_text(t);
    // Short mixed text with lower case
    t = {8'h45, 8'h45, 8'h54, 8'h61, 8'h20, 8'h4F, 8'h45, 8'h7A};
    send_text(t);

    // Random texts, mostly letters; a quiet stretch without idling
    while (bytes_sent < 1600) begin
      quiet = (bytes_sent >= 900 && bytes_sent < 1200);
      n = ($urandom_range(9) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 40);
      t = {};
      repeat (n) t.push_back(rand_char());
      send_text(t);
    end
    quiet = 0;
    in_valid <= 0;
    last <= 0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (3000) @(posedge clk);

    $display("Sent %0d bytes in %0d texts; %0d texts hit saturation.",
             bytes_sent, sb.texts_scored, sb.sat_texts);
    $display("Covered byte extremes, letter ties, long receiver hold-off.");
    if (sb.errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  // Timeout
  initial begin
    #60_000_000;
    $display("Some tests failed");
    $finish;
  end
endmodule

// File: sim.f
+incdir+design
design/slfcs_pkg.sv
design/slfcs_div.sv
design/slfcs_dp.sv
design/slfcs_ctrl.sv
design/sorted_letter_freq_chi_square.sv
verif/sorted_letter_freq_chi_square_tb.sv
